// ===== hw/rtl/md5_message_digest_unit_assert.svh =====
// ----------------------------------------------------------------------------
// MD5 assertion macros
// Clocked implication helpers shared by the MD5 checker.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MD5_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 assertion failed");

`endif

// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Transaction types, sequencer states, round tables and round helpers.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       is_last;
    logic       no_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } md5_state_t;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'(448 / 8);
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts repeat every four rounds within a group of sixteen,
  // so the table is indexed by {group, round mod 4}.
  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    return ROT_AMOUNT[{i[5:4], i[1:0]}];
  endfunction

  // Message word used by round i.
  function automatic logic [3:0] md5_msg_index(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] g;
    j = i[3:0];
    unique case (i[5:4])
      2'd0: g = j;
      2'd1: g = 4'(j * 4'd5 + 4'd1);
      2'd2: g = 4'(j * 4'd3 + 4'd5);
      default: g = 4'(j * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_round_f(input logic [1:0] grp, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (grp)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/md5_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest unit
// Byte-serial MD5 engine with one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Carries
//  msg      in         msg_valid/msg_stall   one message byte, end and empty flags
//  dig      out        dig_valid/dig_stall   four digest words, one per transaction
//
//  The 64th byte of a block starts the rounds and one chaining add, all through
//  the single round unit. The last item adds one padding step per byte up to
//  position 56, one length step, the rounds and chaining add per final block
//  (one or two blocks), then four digest transactions. Reset is synchronous
//  and returns the chaining words and byte count to their start values.
//  msg_stall is high whenever the unit is busy; a stalled digest word holds.
//
module md5_message_digest_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  md5_pkg::md5_in_t msg,
  output logic             dig_valid,
  input  logic             dig_stall,
  output md5_pkg::md5_out_t dig
);
  import md5_pkg::*;

  md5_state_t  state;
  md5_state_t  state_next;
  md5_state_t  ret_state;
  md5_state_t  ret_next;
  logic        start_compress;

  logic [31:0] chain [4];
  logic [31:0] buffer [16];
  logic [63:0] byte_count;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  round_index;
  logic [31:0] kreg;
  logic [5:0]  pad_pos;
  logic        pad_first;
  logic [1:0]  widx;

  logic        msg_accept;
  logic        dig_accept;
  logic [5:0]  round_next_index;
  logic [31:0] round_sum;
  logic [63:0] round_dbl;
  logic [31:0] round_b;
  logic [63:0] bit_length;
  logic [5:0]  byte_pos;

  assign msg_accept = msg_valid && !msg_stall;
  assign dig_accept = dig_valid && !dig_stall;
  assign byte_pos   = byte_count[5:0];
  assign bit_length = {byte_count[60:0], 3'b000};

  // Shared round unit.
  always_comb begin
    round_sum        = wa + md5_round_f(round_index[5:4], wb, wc, wd) + kreg;
    round_dbl        = {round_sum, round_sum} << md5_rot(round_index);
    round_b          = wb + round_dbl[63:32];
    round_next_index = 6'(round_index + 6'd1);
  end

  // Next state.
  always_comb begin
    state_next     = state;
    ret_next       = ret_state;
    start_compress = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (msg_accept) begin
          if (!msg.no_byte && byte_pos == LAST_POS) begin
            state_next     = ST_ROUND;
            ret_next       = msg.is_last ? ST_PAD : ST_IDLE;
            start_compress = 1'b1;
          end else if (msg.is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_pos == LAST_POS) begin
          state_next     = ST_ROUND;
          ret_next       = ST_PAD;
          start_compress = 1'b1;
        end else if (6'(pad_pos + 6'd1) == LEN_POS) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        state_next     = ST_ROUND;
        ret_next       = ST_OUT;
        start_compress = 1'b1;
      end
      ST_ROUND: begin
        if (round_index == LAST_POS) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ret_state;
      end
      ST_OUT: begin
        if (dig_accept && widx == 2'd3) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    msg_stall       = (state != ST_IDLE);
    dig_valid       = (state == ST_OUT);
    dig.digest_word = chain[widx];
    dig.word_index  = widx;
    dig.last_word   = (widx == 2'd3);
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret_state   <= ST_IDLE;
      byte_count  <= '0;
      round_index <= '0;
      pad_pos     <= '0;
      pad_first   <= 1'b0;
      widx        <= '0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= CHAIN_IV[i];
      end
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      if (msg_accept) begin
        pad_first <= 1'b1;
        if (!msg.no_byte) begin
          byte_count <= byte_count + 64'd1;
          pad_pos    <= 6'(byte_pos + 6'd1);
        end else begin
          pad_pos <= byte_pos;
        end
      end
      if (state == ST_PAD) begin
        pad_pos   <= 6'(pad_pos + 6'd1);
        pad_first <= 1'b0;
      end
      if (start_compress) begin
        round_index <= '0;
      end else if (state == ST_ROUND) begin
        round_index <= round_next_index;
      end
      if (state == ST_ADD) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        widx     <= '0;
      end
      if (dig_accept) begin
        widx <= 2'(widx + 2'd1);
        if (widx == 2'd3) begin
          byte_count <= '0;
          for (int i = 0; i < 4; i++) begin
            chain[i] <= CHAIN_IV[i];
          end
        end
      end
    end
  end

  // Block buffer, working registers and the precomputed constant plus word.
  always_ff @(posedge clk) begin
    if (msg_accept && !msg.no_byte) begin
      if (byte_pos[1:0] == 2'd0) begin
        buffer[byte_pos[5:2]] <= {24'h000000, msg.msg_byte};
      end else begin
        buffer[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] <= msg.msg_byte;
      end
    end
    if (state == ST_PAD) begin
      if (pad_pos[1:0] == 2'd0) begin
        buffer[pad_pos[5:2]] <= {24'h000000, (pad_first ? PAD_BYTE : 8'h00)};
      end else begin
        buffer[pad_pos[5:2]][{pad_pos[1:0], 3'b000} +: 8] <= pad_first ? PAD_BYTE : 8'h00;
      end
    end
    if (state == ST_LEN) begin
      buffer[14] <= bit_length[31:0];
      buffer[15] <= bit_length[63:32];
    end
    // The buffer never changes during rounds, so the next round's operand
    // can be added ahead of time and registered in kreg.
    if (start_compress) begin
      wa   <= chain[0];
      wb   <= chain[1];
      wc   <= chain[2];
      wd   <= chain[3];
      kreg <= ROUND_CONST[0] + buffer[0];
    end else if (state == ST_ROUND) begin
      wa   <= wd;
      wb   <= round_b;
      wc   <= wb;
      wd   <= wc;
      kreg <= ROUND_CONST[round_next_index] + buffer[md5_msg_index(round_next_index)];
    end
  end

endmodule

// ===== hw/rtl/md5_checker.sv =====
// ----------------------------------------------------------------------------
// MD5 port checker
// Watches the digest unit's ports for ordering and hold rules.
// ----------------------------------------------------------------------------
`include "md5_message_digest_unit_assert.svh"

module md5_checker (
  input logic              clk,
  input logic              rst,
  input logic              msg_valid,
  input logic              msg_stall,
  input logic              dig_valid,
  input logic              dig_stall,
  input md5_pkg::md5_out_t dig
);
  import md5_pkg::*;

  logic dig_accept;
  logic msg_seen;

  assign dig_accept = dig_valid && !dig_stall;
  assign msg_seen   = msg_valid;

  // No new message byte is taken while the digest is being delivered.
  `MD5_ASSERT_IMPLY(a_busy_during_digest, clk, rst, dig_valid && msg_seen, msg_stall)

  // Digest words leave in order, one index higher each time.
  `MD5_ASSERT_NEXT(a_word_order, clk, rst, dig_accept && !dig.last_word, dig_valid && dig.word_index == 2'($past(dig.word_index) + 2'd1))

  // The final word ends the digest.
  `MD5_ASSERT_NEXT(a_digest_ends, clk, rst, dig_accept && dig.last_word, !dig_valid)

  // The last-word flag marks word three and nothing else.
  `MD5_ASSERT_IMPLY(a_last_flag, clk, rst, dig_valid, dig.last_word == (dig.word_index == 2'd3))

  // A stalled digest word holds.
  `MD5_ASSERT_NEXT(a_dig_hold, clk, rst, dig_valid && dig_stall, dig_valid && $stable(dig))

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest unit testbench
// Streams messages into the unit one byte per transaction and checks every
// digest word against an in-bench MD5 predictor. It opens with a short table
// of directed messages, some with digests typed in. Random messages follow:
// mostly small ones, some at padding and block boundaries, with empty messages
// and ignored items mixed in. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import md5_pkg::*;

  localparam int       RESET_CYCLES   = 11;
  localparam int       QUIET_LIMIT    = 3000;
  localparam int       DRAIN_CYCLES   = 300;
  localparam int       RANDOM_ITEMS   = 400;
  localparam int       MIN_MESSAGES   = 12;
  localparam int       PRINT_LIMIT    = 40;
  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LENGTH_AT    = 6'd56;
  localparam logic [5:0] BLOCK_END    = 6'd63;

  // Digests of well-known short messages, first digest word in the top bits.
  localparam logic [127:0] DIGEST_EMPTY = {32'hd98c1dd4, 32'h04b2008f,
                                           32'h980980e9, 32'h7e42f8ec};
  localparam logic [127:0] DIGEST_A     = {32'hb975c10c, 32'ha8b6f1c0,
                                           32'he299c331, 32'h61267769};
  localparam logic [127:0] DIGEST_ABC   = {32'h98500190, 32'hb04fd23c,
                                           32'h7d3f96d6, 32'h727fe128};

  localparam logic [31:0] START_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFTS [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  localparam int BOUNDARY_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct {
    md5_in_t      item;
    bit           typed;
    logic [127:0] digest;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_stall;
  md5_in_t   msg = '0;
  logic      dig_valid;
  logic      dig_stall = 1'b0;
  md5_out_t  dig;

  md5_message_digest_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  always #10 clk = ~clk;

  // Predictor state: chaining words, block buffer and running byte count.
  logic [31:0] chain [4];
  logic [31:0] block_words [16];
  logic [63:0] byte_total;

  md5_out_t      digest_words_due [$];
  md5_out_t      oldest_due;
  directed_row_t directed_rows [$];
  int            flaws = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            quiet_cycles = 0;
  int            counted_items = 0;
  int            messages_sent = 0;

  task automatic note_mismatch(input string what);
    if (flaws < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
    flaws++;
  endtask

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic run_rounds();
    logic [31:0] a, b, c, d, f, t;
    logic [3:0]  g;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = 4'(r);
        end
        1: begin
          f = (d & b) | (~d & c);
          g = 4'(5 * r + 1);
        end
        2: begin
          f = b ^ c ^ d;
          g = 4'(3 * r + 5);
        end
        default: begin
          f = c ^ (b | ~d);
          g = 4'(7 * r);
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotate_left(a + f + SINE_K[r] + block_words[g], SHIFTS[r / 16][r % 4]);
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endtask

  task automatic place_byte(input logic [5:0] pos, input logic [7:0] value);
    if (pos[1:0] == 2'd0) block_words[pos[5:2]] = '0;
    block_words[pos[5:2]][pos[1:0] * 8 +: 8] = value;
    if (pos == BLOCK_END) run_rounds();
  endtask

  task automatic start_message();
    for (int k = 0; k < 4; k++) chain[k] = START_WORDS[k];
    for (int k = 0; k < 16; k++) block_words[k] = '0;
    byte_total = '0;
  endtask

  // Absorbs one transaction; on the closing one, pads, finishes the digest
  // and returns it with the first digest word in the top bits.
  task automatic absorb_item(input md5_in_t item, output bit done, output logic [127:0] digest);
    logic [63:0] bit_length;
    logic [5:0]  pos;
    done = 1'b0;
    digest = '0;
    if (!item.no_byte) begin
      place_byte(byte_total[5:0], item.msg_byte);
      byte_total++;
    end
    if (item.is_last) begin
      bit_length = byte_total << 3;
      pos = byte_total[5:0];
      place_byte(pos, PAD_MARK);
      pos++;
      while (pos != LENGTH_AT) begin
        place_byte(pos, 8'h00);
        pos++;
      end
      block_words[14] = bit_length[31:0];
      block_words[15] = bit_length[63:32];
      run_rounds();
      digest = {chain[0], chain[1], chain[2], chain[3]};
      done = 1'b1;
      start_message();
    end
  endtask

  task automatic queue_digest(input logic [127:0] digest);
    md5_out_t word;
    for (int k = 0; k < 4; k++) begin
      word.digest_word = digest[127 - 32 * k -: 32];
      word.word_index  = 2'(k);
      word.last_word   = (k == 3);
      digest_words_due.push_back(word);
    end
  endtask

  // Offers one transaction after a random gap and returns once it is taken.
  task automatic send_item(input md5_in_t item, input bit typed, input logic [127:0] typed_digest);
    bit           done;
    logic [127:0] digest;
    while ($urandom_range(0, 99) < idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= item;
    do @(posedge clk); while (msg_stall);
    absorb_item(item, done, digest);
    if (done) begin
      queue_digest(typed ? typed_digest : digest);
      messages_sent++;
    end
  endtask

  function automatic md5_in_t make_item(input logic [7:0] b, input bit last, input bit empty);
    md5_in_t item;
    item.msg_byte = b;
    item.is_last  = last;
    item.no_byte  = empty;
    return item;
  endfunction

  task automatic add_row(input logic [7:0] b, input bit last, input bit empty,
                         input bit typed, input logic [127:0] digest);
    directed_row_t row;
    row.item   = make_item(b, last, empty);
    row.typed  = typed;
    row.digest = digest;
    directed_rows.push_back(row);
  endtask

  task automatic set_phase(input int phase);
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 72; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 72; end
      default: begin idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // Digest side: check what was taken at this edge, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_words_due.size() == 0) begin
        note_mismatch($sformatf("digest word %h with nothing outstanding", dig.digest_word));
      end else begin
        oldest_due = digest_words_due.pop_front();
        if (dig.digest_word !== oldest_due.digest_word)
          note_mismatch($sformatf("word %0d digest_word %h, wanted %h", oldest_due.word_index,
                                  dig.digest_word, oldest_due.digest_word));
        if (dig.word_index !== oldest_due.word_index)
          note_mismatch($sformatf("word_index %0d, wanted %0d", dig.word_index,
                                  oldest_due.word_index));
        if (dig.last_word !== oldest_due.last_word)
          note_mismatch($sformatf("word %0d last_word %b, wanted %b", oldest_due.word_index,
                                  dig.last_word, oldest_due.last_word));
      end
    end
    dig_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int len;
    bit ends_on_byte;
    start_message();

    // Ignored item, empty message, short known messages, byte extremes,
    // an ignored item inside a message, and a message closed by an empty item.
    add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, DIGEST_EMPTY);
    add_row("a",   1'b0, 1'b0, 1'b0, '0);
    add_row("b",   1'b0, 1'b0, 1'b0, '0);
    add_row("c",   1'b1, 1'b0, 1'b1, DIGEST_ABC);
    add_row("a",   1'b1, 1'b0, 1'b1, DIGEST_A);
    add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h3c, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'ha5, 1'b1, 1'b1, 1'b1, DIGEST_EMPTY);
    add_row(8'h7f, 1'b1, 1'b0, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    set_phase(0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].digest);

    // Random messages; ignored items are sprinkled in but not counted.
    while (counted_items < RANDOM_ITEMS || messages_sent < MIN_MESSAGES) begin
      set_phase((counted_items * 4 / RANDOM_ITEMS) > 3 ? 3 : counted_items * 4 / RANDOM_ITEMS);
      if ($urandom_range(0, 9) < 3)
        len = BOUNDARY_LENGTHS[$urandom_range(0, 9)];
      else
        len = $urandom_range(0, 24);
      ends_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(make_item(8'($urandom), 1'b0, 1'b1), 1'b0, '0);
        send_item(make_item(8'($urandom), ends_on_byte && (j == len - 1), 1'b0), 1'b0, '0);
        counted_items++;
      end
      if (!ends_on_byte) begin
        send_item(make_item(8'($urandom), 1'b1, 1'b1), 1'b0, '0);
        counted_items++;
      end
    end
    msg_valid <= 1'b0;

    while (digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (flaws == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/md5_pkg.sv
hw/rtl/md5_message_digest_unit.sv
hw/rtl/md5_checker.sv
bench/testbench.sv
